### hw/rtl/jfps_pkg.sv
package jfps_pkg;

	// Q11.8 sample and index widths
	localparam int VAL_W = 20;
	localparam int IDX_W = 10;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 1;

	// five 20-bit terms fit in 23 bits
	localparam int SUM_W = 23;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [IDX_W-1:0] idx_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PADDED_COLS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PADDED_ROWS = 1'b1;

	localparam val_t VAL_MAX = 20'sh7FFFF;
	localparam val_t VAL_MIN = 20'sh80000;

	// neighbors of one interior pixel
	typedef struct packed {
		val_t up_v;
		val_t down_v;
		val_t left_v;
		val_t right_v;
		val_t edge_v;
	} nbr_t;

endpackage

### hw/rtl/jfps_ram.sv
module jfps_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hw/rtl/jfps_update.sv
module jfps_update (
	input  jfps_pkg::nbr_t nbr,
	output jfps_pkg::val_t result
);

	logic signed [jfps_pkg::SUM_W-1:0] sum;
	logic signed [jfps_pkg::SUM_W-3:0] quo;

	// exact five-term sum, then floor divide by four
	assign sum = jfps_pkg::SUM_W'(nbr.up_v) + jfps_pkg::SUM_W'(nbr.down_v)
		+ jfps_pkg::SUM_W'(nbr.left_v) + jfps_pkg::SUM_W'(nbr.right_v)
		- jfps_pkg::SUM_W'(nbr.edge_v);
	assign quo = sum[jfps_pkg::SUM_W-1:2];

	// saturate to Q11.8
	always_comb begin
		if (quo > jfps_pkg::VAL_MAX) begin
			result = jfps_pkg::VAL_MAX;
		end else if (quo < jfps_pkg::VAL_MIN) begin
			result = jfps_pkg::VAL_MIN;
		end else begin
			result = jfps_pkg::val_t'(quo);
		end
	end

endmodule

### hw/rtl/jacobi_five_point_sweep.sv
// One Jacobi five-point sweep over a padded image streamed in raster order, one padded
// position per request on the input channel. For each interior pixel the block returns
// (up + down + left + right - edge) / 4 (floor, saturated Q11.8) together with its padded
// row and column, once the pixel's lower-right neighbor has arrived; last_of_frame marks
// the final interior pixel. Throughput is one input per clock while the output is not
// stalled; the result for a pixel passes through the stage-1 register and then the output
// register. The previous two rows of old values live in two banks of a MAX_COLS-deep
// line RAM and the previous row of edge values in a third; each bank sees one read and
// at most one write per cycle, which sets the one-per-clock figure. The line RAMs are not
// cleared, so no pass runs after reset. padded_cols and padded_rows are clamped to
// [3, MAX_COLS] and [3, MAX_ROWS] and should be changed only between frames.
module jacobi_five_point_sweep #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [jfps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jfps_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  jfps_pkg::val_t                      old_value,
	input  jfps_pkg::val_t                      edge_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output jfps_pkg::val_t                      new_value,
	output jfps_pkg::idx_t                      pixel_row,
	output jfps_pkg::idx_t                      pixel_col,
	output logic                                last_of_frame
);

	localparam int CA_W = $clog2(MAX_COLS);
	localparam int RA_W = $clog2(MAX_ROWS);
	localparam int CS_W = $clog2(MAX_COLS + 1);
	localparam int RS_W = $clog2(MAX_ROWS + 1);
	localparam int COLS_RST = (642 > MAX_COLS) ? MAX_COLS : 642;
	localparam int ROWS_RST = (482 > MAX_ROWS) ? MAX_ROWS : 482;

	typedef struct packed {
		logic           emit;
		logic           last;
		logic           up_bank;
		jfps_pkg::idx_t row;
		jfps_pkg::idx_t col;
	} ctl_t;

	logic [CS_W-1:0] cols_q;
	logic [RS_W-1:0] rows_q;
	logic [CA_W-1:0] col_q;
	logic [RA_W-1:0] row_q;

	logic           s1_valid_q;
	ctl_t           ctl_s1;
	ctl_t           ctl_in;
	jfps_pkg::val_t ov_s1;
	jfps_pkg::val_t ev_s1;

	jfps_pkg::val_t down_q;
	jfps_pkg::val_t up_q;
	jfps_pkg::val_t edge_q;
	jfps_pkg::val_t right1_q;
	jfps_pkg::val_t right2_q;

	jfps_pkg::val_t bank0_rd;
	jfps_pkg::val_t bank1_rd;
	jfps_pkg::val_t edge_rd;
	jfps_pkg::val_t up_now;
	jfps_pkg::val_t right_now;

	logic           out_valid_q;
	jfps_pkg::val_t new_value_q;
	jfps_pkg::idx_t pixel_row_q;
	jfps_pkg::idx_t pixel_col_q;
	logic           last_q;

	logic           accept;
	logic           s1_move;
	logic           col_wrap;
	logic           row_wrap;
	logic           wr_en;
	logic           wr_bank;
	logic [CA_W-1:0] wr_addr;

	jfps_pkg::nbr_t nbr;
	jfps_pkg::val_t upd_value;

	// handshake: stage 1 drains when it holds no result or the output register can take it
	assign s1_move  = s1_valid_q && (!ctl_s1.emit || !out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_move;
	assign accept   = in_valid && in_ready;

	// raster position bookkeeping
	assign col_wrap = (32'(col_q) + 32'd1) >= 32'(cols_q);
	assign row_wrap = (32'(row_q) + 32'd1) >= 32'(rows_q);

	// classify the incoming position
	always_comb begin
		ctl_in.emit = (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2)
			&& (32'(row_q) < 32'(rows_q)) && (32'(col_q) < 32'(cols_q));
		ctl_in.last = (32'(row_q) == 32'(rows_q) - 32'd1)
			&& (32'(col_q) == 32'(cols_q) - 32'd1);
		ctl_in.up_bank = row_q[0];
		ctl_in.row = jfps_pkg::IDX_W'(32'(row_q) - 32'd1);
		ctl_in.col = jfps_pkg::IDX_W'(32'(col_q) - 32'd1);
	end

	// delayed write of the previous position into the line stores
	assign wr_en   = accept && ((col_q != '0) || (row_q != '0));
	assign wr_bank = (col_q != '0) ? row_q[0] : ~row_q[0];
	assign wr_addr = (col_q != '0) ? (col_q - CA_W'(1)) : CA_W'(cols_q - CS_W'(1));

	jfps_ram #(
		.WIDTH(jfps_pkg::VAL_W),
		.DEPTH(MAX_COLS)
	) u_bank0 (
		.clk  (clk),
		.we   (wr_en && !wr_bank),
		.waddr(wr_addr),
		.wdata(ov_s1),
		.re   (accept),
		.raddr(col_q),
		.rdata(bank0_rd)
	);

	jfps_ram #(
		.WIDTH(jfps_pkg::VAL_W),
		.DEPTH(MAX_COLS)
	) u_bank1 (
		.clk  (clk),
		.we   (wr_en && wr_bank),
		.waddr(wr_addr),
		.wdata(ov_s1),
		.re   (accept),
		.raddr(col_q),
		.rdata(bank1_rd)
	);

	jfps_ram #(
		.WIDTH(jfps_pkg::VAL_W),
		.DEPTH(MAX_COLS)
	) u_edge (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(ev_s1),
		.re   (accept),
		.raddr(col_q),
		.rdata(edge_rd)
	);

	// bank r&1 holds row r-2 (up), the other bank row r-1 (right)
	assign up_now    = ctl_s1.up_bank ? bank1_rd : bank0_rd;
	assign right_now = ctl_s1.up_bank ? bank0_rd : bank1_rd;

	always_comb begin
		nbr.up_v    = up_q;
		nbr.down_v  = down_q;
		nbr.left_v  = right2_q;
		nbr.right_v = right_now;
		nbr.edge_v  = edge_q;
	end

	jfps_update u_update (
		.nbr   (nbr),
		.result(upd_value)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q      <= CS_W'(COLS_RST);
			rows_q      <= RS_W'(ROWS_RST);
			col_q       <= '0;
			row_q       <= '0;
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// size registers, clamped on write
			if (cfg_write) begin
				if (cfg_index == jfps_pkg::CFG_PADDED_COLS) begin
					if (32'(cfg_data) < 32'd3) begin
						cols_q <= CS_W'(3);
					end else if (32'(cfg_data) > 32'(MAX_COLS)) begin
						cols_q <= CS_W'(MAX_COLS);
					end else begin
						cols_q <= CS_W'(cfg_data);
					end
				end else begin
					if (32'(cfg_data) < 32'd3) begin
						rows_q <= RS_W'(3);
					end else if (32'(cfg_data) > 32'(MAX_ROWS)) begin
						rows_q <= RS_W'(MAX_ROWS);
					end else begin
						rows_q <= RS_W'(cfg_data);
					end
				end
			end
			if (accept) begin
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_q + RA_W'(1);
				end else begin
					col_q <= col_q + CA_W'(1);
				end
			end
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_move) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_move && ctl_s1.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// stage 1 payload and neighbor window, shifted once per request
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1   <= ctl_in;
			ov_s1    <= old_value;
			ev_s1    <= edge_value;
			down_q   <= ov_s1;
			up_q     <= up_now;
			edge_q   <= edge_rd;
			right1_q <= right_now;
			right2_q <= right1_q;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (s1_move && ctl_s1.emit) begin
			new_value_q <= upd_value;
			pixel_row_q <= ctl_s1.row;
			pixel_col_q <= ctl_s1.col;
			last_q      <= ctl_s1.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign new_value     = new_value_q;
	assign pixel_row     = pixel_row_q;
	assign pixel_col     = pixel_col_q;
	assign last_of_frame = last_q;

endmodule

### hw/rtl/jfps_checker.sv
module jfps_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input jfps_pkg::val_t new_value,
	input jfps_pkg::idx_t pixel_row,
	input jfps_pkg::idx_t pixel_col,
	input logic           last_of_frame
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_value)
			&& $stable(pixel_row) && $stable(pixel_col) && $stable(last_of_frame))
		else $error("result changed while stalled");

	// with nothing waiting at the output the input must be open
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output");

	// the top halo row and left halo column are never reported
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_row != '0) && (pixel_col != '0))
		else $error("halo position reported");

	// a new frame starts at the first interior pixel
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_of_frame ##1 out_valid |->
			(pixel_row == jfps_pkg::idx_t'(1)) && (pixel_col == jfps_pkg::idx_t'(1)))
		else $error("frame did not restart at the first interior pixel");

endmodule

bind jacobi_five_point_sweep jfps_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.new_value    (new_value),
	.pixel_row    (pixel_row),
	.pixel_col    (pixel_col),
	.last_of_frame(last_of_frame)
);
